// ===== hdl/itar_pkg.sv =====
// ----------------------------------------------------------------------------
// itar_pkg
// Shared types, constants and the digit-to-character mapping for the
// integer to ascii converter.
// ----------------------------------------------------------------------------
`default_nettype none

package itar_pkg;

    localparam int DIV_BITS = 8;
    localparam int COUNT_W  = 5;
    localparam int ROOM_W   = 16;
    localparam int BASE_W   = 5;

    localparam logic [7:0] ASCII_ZERO    = 8'h30;
    localparam logic [7:0] ASCII_MINUS   = 8'h2d;
    localparam logic [7:0] ASCII_UPPER_A = 8'h41;
    localparam logic [7:0] ASCII_LOWER_A = 8'h61;
    localparam logic [7:0] ASCII_NUL     = 8'h00;

    localparam logic [BASE_W-1:0] BASE_MIN = 5'd8;
    localparam logic [BASE_W-1:0] BASE_MAX = 5'd16;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } itar_digit_t;

    typedef struct packed {
        logic              start;
        logic              negative;
        logic              upper;
        logic [ROOM_W-1:0] limit;
    } itar_emit_ctl_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] c;
        if (d < 4'd10) begin
            c = ASCII_ZERO + {4'b0000, d};
        end else if (upper) begin
            c = ASCII_UPPER_A + {4'b0000, d} - 8'd10;
        end else begin
            c = ASCII_LOWER_A + {4'b0000, d} - 8'd10;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/itar_conv.sv =====
// ----------------------------------------------------------------------------
// itar_conv
// Digit generator: repeated division of the magnitude by the base, several
// quotient bits per cycle, least significant digit first.
// ----------------------------------------------------------------------------
`default_nettype none

module itar_conv #(
    parameter int VALUE_WIDTH = 64
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [VALUE_WIDTH-1:0]        magnitude,
    input  wire logic [itar_pkg::BASE_W-1:0]   base,
    output itar_pkg::itar_digit_t              digit,
    output logic                               done
);

    localparam int STEPS  = (VALUE_WIDTH + itar_pkg::DIV_BITS - 1) / itar_pkg::DIV_BITS;
    localparam int QW     = STEPS * itar_pkg::DIV_BITS;
    localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic [QW-1:0]                 quot_reg;
    logic [3:0]                    rem_reg;
    logic [itar_pkg::BASE_W-1:0]   base_reg;
    logic [STEP_W-1:0]             step_reg;
    logic                          busy_reg;

    logic [4:0]                    r;
    logic [itar_pkg::DIV_BITS-1:0] qbits;
    logic [QW-1:0]                 quot_shift;
    logic                          last_step;

    always_comb begin
        r = {1'b0, rem_reg};
        qbits = '0;
        for (int k = itar_pkg::DIV_BITS - 1; k >= 0; k--) begin
            r = {r[3:0], quot_reg[QW-itar_pkg::DIV_BITS+k]};
            if (r >= base_reg) begin
                r = r - base_reg;
                qbits[k] = 1'b1;
            end
        end
    end

    assign quot_shift = {quot_reg[QW-itar_pkg::DIV_BITS-1:0], qbits};
    assign last_step  = (step_reg == STEP_W'(STEPS - 1));

    assign digit.valid = busy_reg && last_step;
    assign digit.value = r[3:0];
    assign done        = busy_reg && last_step && (quot_shift == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end else if (busy_reg) begin
            if (last_step) begin
                step_reg <= '0;
                busy_reg <= (quot_shift != '0);
            end else begin
                step_reg <= step_reg + STEP_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quot_reg <= QW'(magnitude);
            rem_reg  <= 4'd0;
            base_reg <= base;
        end else if (busy_reg) begin
            quot_reg <= quot_shift;
            rem_reg  <= last_step ? 4'd0 : r[3:0];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/itar_emit.sv =====
// ----------------------------------------------------------------------------
// itar_emit
// Digit store and character emitter: sign first, then digits most
// significant first, clipped to the room limit, through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module itar_emit #(
    parameter int DIGIT_DEPTH = 22
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            clear,
    input  wire itar_pkg::itar_digit_t           digit,
    input  wire itar_pkg::itar_emit_ctl_t        ctl,
    output logic                                 done,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [7:0]                           m_character,
    output logic                                 m_last,
    output logic                                 m_nothing_written,
    output logic [itar_pkg::COUNT_W-1:0]         m_count
);

    localparam int IDX_W = (DIGIT_DEPTH > 1) ? $clog2(DIGIT_DEPTH) : 1;
    localparam int CW    = itar_pkg::COUNT_W;

    logic [3:0]    store_mem [DIGIT_DEPTH];
    logic [CW-1:0] count_reg;
    logic          busy_reg;
    logic          neg_pend_reg;
    logic          upper_reg;
    logic [IDX_W-1:0] rd_ptr_reg;
    logic [CW-1:0] sent_reg;
    logic [CW-1:0] total_reg;

    logic          m_valid_reg;
    logic [7:0]    char_reg;
    logic          last_reg;
    logic          none_reg;
    logic [CW-1:0] cnt_reg;

    logic [CW-1:0] len;
    logic [CW-1:0] n_total;
    logic          load;
    logic [7:0]    item_char;
    logic          item_last;
    logic          item_none;
    logic [CW-1:0] item_cnt;

    assign len     = count_reg + {{(CW-1){1'b0}}, ctl.negative};
    assign n_total = ({{(itar_pkg::ROOM_W-CW){1'b0}}, len} > ctl.limit) ?
                     ctl.limit[CW-1:0] : len;
    assign load    = busy_reg && (!m_valid_reg || m_ready);

    always_comb begin
        if (total_reg == '0) begin
            item_char = itar_pkg::ASCII_NUL;
            item_last = 1'b1;
            item_none = 1'b1;
            item_cnt  = '0;
        end else begin
            item_char = neg_pend_reg ? itar_pkg::ASCII_MINUS :
                        itar_pkg::digit_char(store_mem[rd_ptr_reg], upper_reg);
            item_last = (sent_reg + CW'(1) == total_reg);
            item_none = 1'b0;
            item_cnt  = item_last ? total_reg : '0;
        end
    end

    assign done = load && item_last;

    // digit store and fill count
    always_ff @(posedge aclk) begin
        if (digit.valid) begin
            store_mem[count_reg[IDX_W-1:0]] <= digit.value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (clear) begin
            count_reg <= '0;
        end else if (digit.valid) begin
            count_reg <= count_reg + CW'(1);
        end
    end

    // emission sequencing
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (ctl.start) begin
            busy_reg <= 1'b1;
        end else if (load && item_last) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            neg_pend_reg <= ctl.negative;
            upper_reg    <= ctl.upper;
            rd_ptr_reg   <= IDX_W'(count_reg - CW'(1));
            sent_reg     <= '0;
            total_reg    <= n_total;
        end else if (load) begin
            sent_reg <= sent_reg + CW'(1);
            if (neg_pend_reg) begin
                neg_pend_reg <= 1'b0;
            end else begin
                rd_ptr_reg <= rd_ptr_reg - IDX_W'(1);
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            char_reg <= item_char;
            last_reg <= item_last;
            none_reg <= item_none;
            cnt_reg  <= item_cnt;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_character       = char_reg;
    assign m_last            = last_reg;
    assign m_nothing_written = none_reg;
    assign m_count           = cnt_reg;

endmodule

`default_nettype wire

// ===== hdl/integer_to_ascii_radix.sv =====
// ----------------------------------------------------------------------------
// integer_to_ascii_radix
// Converts an integer to ASCII digits in a base from 8 to 16, sign first,
// most significant digit first, clipped to the room left in the buffer.
// ----------------------------------------------------------------------------
// operation: the divider yields each digit in one pass of 8 quotient bits a
//   cycle over a 64-bit operand; the launch state and the output register
//   come before the first character, then one character per cycle while the receiver is ready
// throughput: one transaction at a time
// reset: synchronous active low, clears control state, no clearing pass
`default_nettype none

module integer_to_ascii_radix #(
    parameter int VALUE_WIDTH = 64
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [63:0]                    s_value,
    input  wire logic                           s_is_signed,
    input  wire logic [itar_pkg::BASE_W-1:0]    s_base,
    input  wire logic                           s_uppercase,
    input  wire logic [itar_pkg::ROOM_W-1:0]    s_room,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [7:0]                          m_character,
    output logic                                m_last,
    output logic                                m_nothing_written,
    output logic [itar_pkg::COUNT_W-1:0]        m_count
);

    localparam int DIGIT_DEPTH = (VALUE_WIDTH + 2) / 3;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_CONV   = 4'b0010,
        ST_LAUNCH = 4'b0100,
        ST_EMIT   = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic                          accept;
    logic [VALUE_WIDTH-1:0]        raw;
    logic                          neg;
    logic [VALUE_WIDTH-1:0]        magnitude;
    logic [itar_pkg::BASE_W-1:0]   base_clamped;
    logic                          neg_reg;
    logic                          upper_reg;
    logic [itar_pkg::ROOM_W-1:0]   limit_reg;

    itar_pkg::itar_digit_t         digit;
    itar_pkg::itar_emit_ctl_t      emit_ctl;
    logic                          conv_done;
    logic                          emit_done;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    assign raw       = s_value[VALUE_WIDTH-1:0];
    assign neg       = s_is_signed && raw[VALUE_WIDTH-1];
    assign magnitude = neg ? (~raw + VALUE_WIDTH'(1)) : raw;

    always_comb begin
        priority if (s_base < itar_pkg::BASE_MIN) begin
            base_clamped = itar_pkg::BASE_MIN;
        end else if (s_base > itar_pkg::BASE_MAX) begin
            base_clamped = itar_pkg::BASE_MAX;
        end else begin
            base_clamped = s_base;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            neg_reg   <= neg;
            upper_reg <= s_uppercase;
            limit_reg <= (s_room == '0) ? '0 : s_room - itar_pkg::ROOM_W'(1);
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (accept) state_next = ST_CONV;
            ST_CONV:   if (conv_done) state_next = ST_LAUNCH;
            ST_LAUNCH: state_next = ST_EMIT;
            ST_EMIT:   if (emit_done) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign emit_ctl.start    = (state_reg == ST_LAUNCH);
    assign emit_ctl.negative = neg_reg;
    assign emit_ctl.upper    = upper_reg;
    assign emit_ctl.limit    = limit_reg;

    itar_conv #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_conv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (accept),
        .magnitude (magnitude),
        .base      (base_clamped),
        .digit     (digit),
        .done      (conv_done)
    );

    itar_emit #(
        .DIGIT_DEPTH (DIGIT_DEPTH)
    ) u_emit (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .clear             (accept),
        .digit             (digit),
        .ctl               (emit_ctl),
        .done              (emit_done),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_character       (m_character),
        .m_last            (m_last),
        .m_nothing_written (m_nothing_written),
        .m_count           (m_count)
    );

    // assertions
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while a conversion is in flight");

    a_empty_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_nothing_written) |-> (m_last && m_count == '0))
        else $error("empty transaction not final or with nonzero count");

    a_count_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_last) |-> (m_count == '0 && !m_nothing_written))
        else $error("count or empty flag on a non-final transaction");

    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last && !m_nothing_written) |-> (m_count != '0))
        else $error("final character transaction with zero count");

endmodule

`default_nettype wire

// ===== tb/integer_to_ascii_radix_tb.sv =====
// ----------------------------------------------------------------------------
// integer_to_ascii_radix_tb
// Self-checking bench for the integer to ascii converter. A directed table
// covers the extremes, base clamping and the buffer-room cases, then random
// conversions run under four idle/stall phases with one long receiver hold.
// Every transaction is checked against the table text or a software predictor.
// ----------------------------------------------------------------------------
module integer_to_ascii_radix_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int VALUE_WIDTH      = 64;
    localparam int DIGIT_DEPTH      = 22;
    localparam int RANDOM_PER_PHASE = 82;
    localparam int HOLD_CYCLES      = 600;
    localparam int DRAIN_CYCLES     = 250;
    localparam int STALL_LIMIT      = 5000;
    localparam int REPORT_LIMIT     = 10;

    typedef struct {
        logic [63:0]                 value;
        logic                        is_signed;
        logic [itar_pkg::BASE_W-1:0] base;
        logic                        uppercase;
        logic [itar_pkg::ROOM_W-1:0] room;
        bit                          known;
        string                       text;
    } conversion_t;

    typedef struct packed {
        logic [7:0]                   character;
        logic                         last;
        logic                         nothing_written;
        logic [itar_pkg::COUNT_W-1:0] count;
    } char_item_t;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    logic [63:0]                   s_value;
    logic                          s_is_signed;
    logic [itar_pkg::BASE_W-1:0]   s_base;
    logic                          s_uppercase;
    logic [itar_pkg::ROOM_W-1:0]   s_room;
    logic                          m_valid;
    logic                          m_ready;
    logic [7:0]                    m_character;
    logic                          m_last;
    logic                          m_nothing_written;
    logic [itar_pkg::COUNT_W-1:0]  m_count;

    char_item_t  expected_chars[$];
    logic [7:0]  digit_text[$];
    conversion_t directed_rows[$];

    int failures       = 0;
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int hold_left      = 0;
    int stall_cycles   = 0;
    bit hold_pending   = 0;

    integer_to_ascii_radix #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_value(s_value),
        .s_is_signed(s_is_signed),
        .s_base(s_base),
        .s_uppercase(s_uppercase),
        .s_room(s_room),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_character(m_character),
        .m_last(m_last),
        .m_nothing_written(m_nothing_written),
        .m_count(m_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic void note_failure(input string msg);
        failures++;
        if (failures <= REPORT_LIMIT) begin
            $display("[%0t] %s", $realtime, msg);
        end
    endfunction

    // full sign and digit text, most significant first, before clipping
    function automatic void predict_characters(input conversion_t c);
        logic [63:0]                 mask;
        logic [63:0]                 raw;
        logic [63:0]                 magnitude;
        logic [itar_pkg::BASE_W-1:0] radix;
        logic [3:0]                  digits[DIGIT_DEPTH];
        int                          ndigits;
        bit                          negative;
        string                       charset;
        mask = {64{1'b1}} >> (64 - VALUE_WIDTH);
        raw = c.value & mask;
        if (c.base < itar_pkg::BASE_MIN) begin
            radix = itar_pkg::BASE_MIN;
        end else if (c.base > itar_pkg::BASE_MAX) begin
            radix = itar_pkg::BASE_MAX;
        end else begin
            radix = c.base;
        end
        negative = c.is_signed && raw[VALUE_WIDTH-1];
        magnitude = negative ? ((~raw + 64'd1) & mask) : raw;
        charset = c.uppercase ? "0123456789ABCDEF" : "0123456789abcdef";
        ndigits = 0;
        if (magnitude == 64'd0) begin
            digits[0] = 4'd0;
            ndigits = 1;
        end
        while (magnitude != 64'd0 && ndigits < DIGIT_DEPTH) begin
            digits[ndigits] = 4'(magnitude % 64'(radix));
            magnitude = magnitude / 64'(radix);
            ndigits++;
        end
        if (negative) begin
            digit_text.push_back(itar_pkg::ASCII_MINUS);
        end
        for (int i = ndigits - 1; i >= 0; i--) begin
            digit_text.push_back(charset[digits[i]]);
        end
    endfunction

    // clip to room minus one and turn the text into character transactions
    function automatic void queue_text(input logic [itar_pkg::ROOM_W-1:0] room);
        int         room_chars;
        int         n;
        char_item_t item;
        room_chars = (room == '0) ? 0 : int'(room) - 1;
        n = (digit_text.size() < room_chars) ? digit_text.size() : room_chars;
        if (n == 0) begin
            item = '{itar_pkg::ASCII_NUL, 1'b1, 1'b1, '0};
            expected_chars.push_back(item);
        end else begin
            for (int i = 0; i < n; i++) begin
                item.character       = digit_text[i];
                item.last            = (i == n - 1);
                item.nothing_written = 1'b0;
                item.count           = (i == n - 1) ? itar_pkg::COUNT_W'(n) : '0;
                expected_chars.push_back(item);
            end
        end
    endfunction

    // called just after a falling edge, returns just after a falling edge
    task automatic send_conversion(input conversion_t c);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_value     <= c.value;
        s_is_signed <= c.is_signed;
        s_base      <= c.base;
        s_uppercase <= c.uppercase;
        s_room      <= c.room;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        digit_text.delete();
        if (c.known) begin
            for (int i = 0; i < c.text.len(); i++) begin
                digit_text.push_back(c.text[i]);
            end
        end else begin
            predict_characters(c);
        end
        queue_text(c.room);
        @(negedge aclk);
    endtask

    // receiver ready, with an optional long hold counted here
    always @(negedge aclk) begin
        if (hold_pending) begin
            hold_pending = 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    always @(posedge aclk) begin
        char_item_t got;
        char_item_t want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_character, m_last, m_nothing_written, m_count};
            if (expected_chars.size() == 0) begin
                note_failure($sformatf("unexpected transaction char=%02h last=%0b none=%0b count=%0d",
                                       got.character, got.last, got.nothing_written, got.count));
            end else begin
                want = expected_chars.pop_front();
                if (got !== want) begin
                    note_failure($sformatf({"mismatch: expected char=%02h last=%0b none=%0b ",
                                            "count=%0d, got char=%02h last=%0b none=%0b count=%0d"},
                                           want.character, want.last, want.nothing_written,
                                           want.count, got.character, got.last,
                                           got.nothing_written, got.count));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    initial begin
        conversion_t c;
        int          shift;
        int          src_phase[4]  = '{0, 53, 0, 20};
        int          sink_phase[4] = '{0, 0, 53, 20};

        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_value     = '0;
        s_is_signed = 1'b0;
        s_base      = '0;
        s_uppercase = 1'b0;
        s_room      = '0;

        directed_rows.push_back('{64'd0, 1'b0, 5'd10, 1'b0, 16'd100, 1'b1, "0"});
        directed_rows.push_back('{'1, 1'b0, 5'd16, 1'b1, 16'd100, 1'b1, "FFFFFFFFFFFFFFFF"});
        directed_rows.push_back('{'1, 1'b0, 5'd16, 1'b0, 16'd100, 1'b1, "ffffffffffffffff"});
        directed_rows.push_back('{'1, 1'b1, 5'd10, 1'b0, 16'd100, 1'b1, "-1"});
        directed_rows.push_back('{64'h8000_0000_0000_0000, 1'b1, 5'd16, 1'b1, 16'd100, 1'b1,
                                  "-8000000000000000"});
        directed_rows.push_back('{64'h8000_0000_0000_0000, 1'b1, 5'd8, 1'b0, 16'd100, 1'b1,
                                  "-1000000000000000000000"});
        directed_rows.push_back('{'1, 1'b0, 5'd8, 1'b0, 16'd100, 1'b1,
                                  "1777777777777777777777"});
        directed_rows.push_back('{64'h7fff_ffff_ffff_ffff, 1'b1, 5'd10, 1'b0, 16'd100, 1'b1,
                                  "9223372036854775807"});
        directed_rows.push_back('{'1, 1'b0, 5'd10, 1'b0, 16'hffff, 1'b1,
                                  "18446744073709551615"});
        directed_rows.push_back('{64'd12345, 1'b0, 5'd10, 1'b0, 16'd0, 1'b1, ""});
        directed_rows.push_back('{64'd12345, 1'b0, 5'd10, 1'b0, 16'd1, 1'b1, ""});
        directed_rows.push_back('{64'd12345, 1'b0, 5'd10, 1'b0, 16'd2, 1'b1, "1"});
        directed_rows.push_back('{64'hffff_ffff_ffff_fffb, 1'b1, 5'd10, 1'b0, 16'd2, 1'b1, "-"});
        directed_rows.push_back('{64'd8, 1'b0, 5'd0, 1'b0, 16'd100, 1'b1, "10"});
        directed_rows.push_back('{64'd255, 1'b0, 5'd31, 1'b0, 16'd100, 1'b1, "ff"});
        directed_rows.push_back('{64'd255, 1'b0, 5'd17, 1'b1, 16'd100, 1'b1, "FF"});
        directed_rows.push_back('{64'h8000_0000_0000_0000, 1'b0, 5'd16, 1'b0, 16'd100, 1'b1,
                                  "8000000000000000"});
        directed_rows.push_back('{64'd1, 1'b1, 5'd10, 1'b0, 16'd100, 1'b1, "1"});
        directed_rows.push_back('{64'h0123_4567_89ab_cdef, 1'b0, 5'd9, 1'b1, 16'd100, 1'b0, ""});
        directed_rows.push_back('{64'hfedc_ba98_7654_3210, 1'b1, 5'd11, 1'b0, 16'd100, 1'b0, ""});
        directed_rows.push_back('{64'h9e37_79b9_7f4a_7c15, 1'b0, 5'd12, 1'b1, 16'd100, 1'b0, ""});
        directed_rows.push_back('{64'h5555_5555_5555_5555, 1'b1, 5'd13, 1'b0, 16'd100, 1'b0, ""});
        directed_rows.push_back('{64'haaaa_aaaa_aaaa_aaaa, 1'b1, 5'd14, 1'b1, 16'd100, 1'b0, ""});
        directed_rows.push_back('{64'h1234_5678_9abc_def0, 1'b0, 5'd15, 1'b0, 16'd7, 1'b0, ""});
        directed_rows.push_back('{64'habcd_ef01_2345_6789, 1'b0, 5'd10, 1'b1, 16'hffff, 1'b0, ""});

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[i]) begin
            send_conversion(directed_rows[i]);
        end

        for (int phase = 0; phase < 4; phase++) begin
            src_idle_pct   = src_phase[phase];
            sink_stall_pct = sink_phase[phase];
            if (phase == 0) begin
                hold_pending = 1'b1;
            end
            for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
                c.value = {$urandom, $urandom};
                shift   = $urandom_range(0, 63);
                case ($urandom_range(0, 3))
                    0: ;
                    1: c.value = c.value >> shift;
                    2: c.value = -(c.value >> shift);
                    default: c.value = 64'($urandom_range(0, 1000));
                endcase
                c.is_signed = 1'($urandom_range(0, 1));
                c.base      = ($urandom_range(0, 9) == 0)
                              ? itar_pkg::BASE_W'($urandom_range(0, 31))
                              : itar_pkg::BASE_W'($urandom_range(8, 16));
                c.uppercase = 1'($urandom_range(0, 1));
                case ($urandom_range(0, 9))
                    0, 1, 2: c.room = itar_pkg::ROOM_W'($urandom);
                    3, 4:    c.room = itar_pkg::ROOM_W'($urandom_range(0, 24));
                    default: c.room = itar_pkg::ROOM_W'($urandom_range(24, 64));
                endcase
                c.known = 1'b0;
                c.text  = "";
                send_conversion(c);
            end
        end
        s_valid <= 1'b0;

        while (expected_chars.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (failures == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
